// ----- hw/rtl/ngft_pkg.sv -----
// ----------------------------------------------------------------------------
// ngft_pkg
// Shared types, codes and constants of the n-gram frequency block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ngft_pkg;

   localparam int CHAR_W     = 8;
   localparam int RANK_W     = 2;
   localparam int TOP_COUNT  = 3;
   localparam int OUT_TOK_W  = 16;
   localparam int COUNT_W    = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] OP_CHAR   = 2'd0;
   localparam logic [1:0] OP_REPORT = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic              REG_EXCLUDED = 1'b0;
   localparam logic [CHAR_W-1:0] EXCL_RESET   = 8'd46;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_REPORT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic full;
      logic skip;
   } win_status_type;

   typedef struct packed {
      logic clear;
      logic load;
   } rank_ctrl_type;

   function automatic logic is_blank(input logic [CHAR_W-1:0] c);
      is_blank = (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

endpackage

// ----- hw/rtl/ngft_ram.sv -----
// ----------------------------------------------------------------------------
// ngft_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ngft_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/ngft_window.sv -----
// ----------------------------------------------------------------------------
// ngft_window
// Sliding character window; forms the token and the excluded-char flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ngft_window #(
   parameter int WINDOW_LEN = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          shift,
   input  logic                          clear,
   input  logic [ngft_pkg::CHAR_W-1:0]   char_in,
   input  logic [ngft_pkg::CHAR_W-1:0]   excluded,
   output ngft_pkg::win_status_type      status,
   output logic [8*WINDOW_LEN-1:0]       token
);

   localparam int HOLD  = WINDOW_LEN - 1;
   localparam int CNT_W = $clog2(WINDOW_LEN);

   logic [ngft_pkg::CHAR_W-1:0] chars_ff [HOLD];
   logic [ngft_pkg::CHAR_W-1:0] chars_in [HOLD];
   logic [CNT_W-1:0]            cnt_ff;
   logic [CNT_W-1:0]            cnt_in;
   logic                        full;
   logic                        skip;

   assign full = (cnt_ff == CNT_W'(HOLD));

   always_comb begin
      token = '0;
      skip  = (char_in == excluded);
      for (int i = 0; i < HOLD; i++) begin
         token[8*(HOLD-i) +: 8] = chars_ff[i];
         if (chars_ff[i] == excluded) begin
            skip = 1'b1;
         end
      end
      token[7:0] = char_in;
   end

   assign status.full = full;
   assign status.skip = skip;

   // shift appends at the young end unless clear is high; once full, order matches
   always_comb begin
      cnt_in = cnt_ff;
      for (int i = 0; i < HOLD; i++) begin
         chars_in[i] = chars_ff[i];
      end
      if (clear) begin
         cnt_in = '0;
         for (int i = 0; i < HOLD; i++) begin
            chars_in[i] = '0;
         end
      end else if (shift) begin
         for (int i = 0; i < HOLD - 1; i++) begin
            chars_in[i] = chars_ff[i+1];
         end
         chars_in[HOLD-1] = char_in;
         if (!full) begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         for (int i = 0; i < HOLD; i++) begin
            chars_ff[i] <= '0;
         end
      end else begin
         cnt_ff <= cnt_in;
         for (int i = 0; i < HOLD; i++) begin
            chars_ff[i] <= chars_in[i];
         end
      end
   end

endmodule

// ----- hw/rtl/ngft_rank.sv -----
// ----------------------------------------------------------------------------
// ngft_rank
// Top-three register list; inserts one scanned entry per cycle while load is set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ngft_rank (
   input  logic                                clock,
   input  ngft_pkg::rank_ctrl_type             ctrl,
   input  logic [ngft_pkg::COUNT_W-1:0]        cnt_in,
   input  logic [ngft_pkg::OUT_TOK_W-1:0]      tok_in,
   output logic [ngft_pkg::OUT_TOK_W-1:0]      best_tok [ngft_pkg::TOP_COUNT],
   output logic [ngft_pkg::COUNT_W-1:0]        best_cnt [ngft_pkg::TOP_COUNT]
);

   logic [ngft_pkg::OUT_TOK_W-1:0] tok_ff  [ngft_pkg::TOP_COUNT];
   logic [ngft_pkg::OUT_TOK_W-1:0] tok_nx  [ngft_pkg::TOP_COUNT];
   logic [ngft_pkg::COUNT_W-1:0]   cnt_ff  [ngft_pkg::TOP_COUNT];
   logic [ngft_pkg::COUNT_W-1:0]   cnt_nx  [ngft_pkg::TOP_COUNT];
   logic [ngft_pkg::TOP_COUNT-1:0] gt;

   // strict compare: ties keep the earlier entry
   always_comb begin
      for (int j = 0; j < ngft_pkg::TOP_COUNT; j++) begin
         gt[j]     = (cnt_in > cnt_ff[j]);
         tok_nx[j] = tok_ff[j];
         cnt_nx[j] = cnt_ff[j];
      end
      for (int j = 0; j < ngft_pkg::TOP_COUNT; j++) begin
         if (ctrl.clear) begin
            tok_nx[j] = '0;
            cnt_nx[j] = '0;
         end else if (ctrl.load) begin
            if ((j > 0) && gt[(j > 0) ? j-1 : 0]) begin
               tok_nx[j] = tok_ff[(j > 0) ? j-1 : 0];
               cnt_nx[j] = cnt_ff[(j > 0) ? j-1 : 0];
            end else if (gt[j]) begin
               tok_nx[j] = tok_in;
               cnt_nx[j] = cnt_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < ngft_pkg::TOP_COUNT; j++) begin
         tok_ff[j] <= tok_nx[j];
         cnt_ff[j] <= cnt_nx[j];
      end
   end

   always_comb begin
      for (int j = 0; j < ngft_pkg::TOP_COUNT; j++) begin
         best_tok[j] = tok_ff[j];
         best_cnt[j] = cnt_ff[j];
      end
   end

endmodule

// ----- hw/rtl/ngram_frequency_top_three.sv -----
// ----------------------------------------------------------------------------
// ngram_frequency_top_three
// N-gram histogram over a character stream with a top-three report. A
// character request that is whitespace, only fills the window, or forms a
// skipped window completes in the idle state; otherwise a lookup scan reads
// one table entry per cycle, up to the fill level, through the single read
// port of the token/count RAMs, and stops early on a hit. A report scans the
// table through the same port and then holds its three results on the
// response channel, one per handshake. Clear and unused operations complete
// in the idle state. The block takes one request at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ngram_frequency_top_three #(
   parameter int TABLE_DEPTH = 128,
   parameter int WINDOW_LEN  = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_operation,
   input  logic [ngft_pkg::CHAR_W-1:0]          req_char_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ngft_pkg::RANK_W-1:0]          rsp_rank,
   output logic [ngft_pkg::OUT_TOK_W-1:0]       rsp_token_out,
   output logic [ngft_pkg::COUNT_W-1:0]         rsp_count_out,
   output logic                                 rsp_overflow,
   output logic                                 rsp_last,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ngft_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [ngft_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [ngft_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int TOK_W = 8 * WINDOW_LEN;

   ngft_pkg::state_type             state_ff, state_in;
   logic [CNT_W-1:0]                rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]                fill_ff, fill_in;
   logic                            pend_ff, pend_in;
   logic [IDX_W-1:0]                pend_idx_ff, pend_idx_in;
   logic                            ovf_ff, ovf_in;
   logic [TOK_W-1:0]                tok_ff, tok_in;
   logic [ngft_pkg::RANK_W-1:0]     emit_ff, emit_in;
   logic [ngft_pkg::CHAR_W-1:0]     excl_ff, excl_in;

   logic                            rd_en;
   logic                            tok_we;
   logic                            cnt_we;
   logic [IDX_W-1:0]                wr_addr;
   logic [ngft_pkg::COUNT_W-1:0]    cnt_wdata;
   logic [TOK_W-1:0]                tok_rd;
   logic [ngft_pkg::COUNT_W-1:0]    cnt_rd;
   logic                            hit;
   logic                            csr_wr;

   logic                            win_shift;
   logic                            win_clear;
   ngft_pkg::win_status_type        win_status;
   logic [TOK_W-1:0]                win_token;
   ngft_pkg::rank_ctrl_type         rank_ctrl;
   logic [ngft_pkg::OUT_TOK_W-1:0]  best_tok [ngft_pkg::TOP_COUNT];
   logic [ngft_pkg::COUNT_W-1:0]    best_cnt [ngft_pkg::TOP_COUNT];

   ngft_ram #(
      .WIDTH (TOK_W),
      .DEPTH (TABLE_DEPTH)
   ) u_tok_ram (
      .clock   (clock),
      .wr_en   (tok_we),
      .wr_addr (wr_addr),
      .wr_data (tok_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (tok_rd)
   );

   ngft_ram #(
      .WIDTH (ngft_pkg::COUNT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (wr_addr),
      .wr_data (cnt_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (cnt_rd)
   );

   ngft_window #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .shift    (win_shift),
      .clear    (win_clear),
      .char_in  (req_char_in),
      .excluded (excl_ff),
      .status   (win_status),
      .token    (win_token)
   );

   ngft_rank u_rank (
      .clock    (clock),
      .ctrl     (rank_ctrl),
      .cnt_in   (cnt_rd),
      .tok_in   (tok_rd[ngft_pkg::OUT_TOK_W-1:0]),
      .best_tok (best_tok),
      .best_cnt (best_cnt)
   );

   // config port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[ngft_pkg::CSR_ADDR_W-1] == ngft_pkg::REG_EXCLUDED) ?
                       ngft_pkg::CSR_DATA_W'(excl_ff) : '0;

   always_comb begin
      excl_in = excl_ff;
      if (csr_wr && (csr_paddr[ngft_pkg::CSR_ADDR_W-1] == ngft_pkg::REG_EXCLUDED)) begin
         excl_in = csr_pwdata[ngft_pkg::CHAR_W-1:0];
      end
   end

   assign hit = pend_ff && (tok_rd == tok_ff);

   always_comb begin
      state_in    = state_ff;
      rd_idx_in   = rd_idx_ff;
      fill_in     = fill_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      ovf_in      = ovf_ff;
      tok_in      = tok_ff;
      emit_in     = emit_ff;
      rd_en       = 1'b0;
      tok_we      = 1'b0;
      cnt_we      = 1'b0;
      wr_addr     = pend_idx_ff;
      cnt_wdata   = '0;
      win_shift   = 1'b0;
      win_clear   = 1'b0;
      rank_ctrl   = '0;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;

      case (state_ff)
         ngft_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_operation)
                  ngft_pkg::OP_CHAR: begin
                     if (!ngft_pkg::is_blank(req_char_in)) begin
                        win_shift = 1'b1;
                        if (win_status.full && !win_status.skip) begin
                           tok_in    = win_token;
                           rd_idx_in = '0;
                           state_in  = ngft_pkg::ST_LOOKUP;
                        end
                     end
                  end
                  ngft_pkg::OP_REPORT: begin
                     rank_ctrl.clear = 1'b1;
                     rd_idx_in       = '0;
                     state_in        = ngft_pkg::ST_REPORT;
                  end
                  ngft_pkg::OP_CLEAR: begin
                     fill_in   = '0;
                     ovf_in    = 1'b0;
                     win_clear = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ngft_pkg::ST_LOOKUP: begin
            if (hit) begin
               cnt_we    = 1'b1;
               wr_addr   = pend_idx_ff;
               cnt_wdata = (cnt_rd == '1) ? cnt_rd : cnt_rd + 1'b1;
               state_in  = ngft_pkg::ST_IDLE;
            end else if (rd_idx_ff == fill_ff) begin
               if (fill_ff != CNT_W'(TABLE_DEPTH)) begin
                  tok_we    = 1'b1;
                  cnt_we    = 1'b1;
                  wr_addr   = fill_ff[IDX_W-1:0];
                  cnt_wdata = ngft_pkg::COUNT_W'(1);
                  fill_in   = fill_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               state_in = ngft_pkg::ST_IDLE;
            end else begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff[IDX_W-1:0];
               rd_idx_in   = rd_idx_ff + 1'b1;
            end
         end

         ngft_pkg::ST_REPORT: begin
            rank_ctrl.load = pend_ff;
            if (rd_idx_ff == fill_ff) begin
               emit_in  = '0;
               state_in = ngft_pkg::ST_EMIT;
            end else begin
               rd_en       = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = rd_idx_ff[IDX_W-1:0];
               rd_idx_in   = rd_idx_ff + 1'b1;
            end
         end

         ngft_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (emit_ff == ngft_pkg::RANK_W'(ngft_pkg::TOP_COUNT - 1)) begin
                  state_in = ngft_pkg::ST_IDLE;
               end else begin
                  emit_in = emit_ff + 1'b1;
               end
            end
         end

         default: begin
            state_in = ngft_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ngft_pkg::ST_IDLE;
         rd_idx_ff <= '0;
         fill_ff   <= '0;
         pend_ff   <= 1'b0;
         ovf_ff    <= 1'b0;
         emit_ff   <= '0;
         excl_ff   <= ngft_pkg::EXCL_RESET;
      end else begin
         state_ff  <= state_in;
         rd_idx_ff <= rd_idx_in;
         fill_ff   <= fill_in;
         pend_ff   <= pend_in;
         ovf_ff    <= ovf_in;
         emit_ff   <= emit_in;
         excl_ff   <= excl_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= pend_idx_in;
      tok_ff      <= tok_in;
   end

   assign rsp_rank      = emit_ff;
   assign rsp_token_out = best_tok[emit_ff];
   assign rsp_count_out = best_cnt[emit_ff];
   assign rsp_overflow  = ovf_ff;
   assign rsp_last      = (emit_ff == ngft_pkg::RANK_W'(ngft_pkg::TOP_COUNT - 1));

   // checks
   a_busy_while_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while results pending");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(TABLE_DEPTH))
      else $error("fill level beyond table depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_operation == ngft_pkg::OP_CLEAR))
      |=> ((fill_ff == '0) && !ovf_ff))
      else $error("clear did not empty table");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last) |=> req_ready)
      else $error("not ready after final result");

endmodule

// ----- dv/ngram_frequency_top_three_check.sv -----
// ----------------------------------------------------------------------------
// ngram_frequency_top_three_check
// Passive checker for the bigram histogram block. It follows the request,
// result and register ports, keeps its own bigram table, window and
// excluded character, and ranks the table on every report request. Each
// result is compared field by field with the oldest ranking still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ngram_frequency_top_three_check #(
   parameter int TABLE_DEPTH = 128
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [1:0]                        req_operation,
   input  logic [ngft_pkg::CHAR_W-1:0]       req_char_in,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic [ngft_pkg::RANK_W-1:0]       rsp_rank,
   input  logic [ngft_pkg::OUT_TOK_W-1:0]    rsp_token_out,
   input  logic [ngft_pkg::COUNT_W-1:0]      rsp_count_out,
   input  logic                              rsp_overflow,
   input  logic                              rsp_last,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ngft_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [ngft_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   input  logic [ngft_pkg::CSR_DATA_W-1:0]   csr_prdata,
   input  logic                              csr_pready,
   output int                                errors,
   output int                                pending
);

   localparam logic [ngft_pkg::COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [ngft_pkg::RANK_W-1:0]    rank;
      logic [ngft_pkg::OUT_TOK_W-1:0] token;
      logic [ngft_pkg::COUNT_W-1:0]   count;
      logic                           overflow;
      logic                           last;
   } ranking_type;

   logic [ngft_pkg::CHAR_W-1:0]    excl_char;
   logic [ngft_pkg::CHAR_W-1:0]    held_char;
   logic                           held_valid;
   logic [ngft_pkg::OUT_TOK_W-1:0] token_table [TABLE_DEPTH];
   logic [ngft_pkg::COUNT_W-1:0]   count_table [TABLE_DEPTH];
   int                             table_fill;
   logic                           dropped;
   ranking_type                    ranking_q [$];
   int                             mismatch_count = 0;

   assign errors = mismatch_count;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic bit is_whitespace(input logic [ngft_pkg::CHAR_W-1:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   task automatic take_char(input logic [ngft_pkg::CHAR_W-1:0] c);
      logic [ngft_pkg::OUT_TOK_W-1:0] tok;
      bit                             skip;
      bit                             found;
      if (is_whitespace(c))
         return;
      if (!held_valid) begin
         held_char  = c;
         held_valid = 1'b1;
         return;
      end
      tok       = {held_char, c};
      skip      = (held_char == excl_char) || (c == excl_char);
      held_char = c;
      if (skip)
         return;
      found = 1'b0;
      for (int i = 0; i < table_fill && !found; i++) begin
         if (token_table[i] == tok) begin
            found = 1'b1;
            if (count_table[i] != COUNT_MAX)
               count_table[i] = count_table[i] + 1'b1;
         end
      end
      if (!found) begin
         if (table_fill < TABLE_DEPTH) begin
            token_table[table_fill] = tok;
            count_table[table_fill] = 1;
            table_fill++;
         end else begin
            dropped = 1'b1;
         end
      end
   endtask

   // ties keep the earlier entry: only a strictly larger count moves up
   task automatic push_ranking();
      logic [ngft_pkg::OUT_TOK_W-1:0] top_tok [ngft_pkg::TOP_COUNT];
      logic [ngft_pkg::COUNT_W-1:0]   top_cnt [ngft_pkg::TOP_COUNT];
      ranking_type                    r;
      bit                             placed;
      for (int j = 0; j < ngft_pkg::TOP_COUNT; j++) begin
         top_tok[j] = '0;
         top_cnt[j] = '0;
      end
      for (int i = 0; i < table_fill; i++) begin
         placed = 1'b0;
         for (int j = 0; j < ngft_pkg::TOP_COUNT && !placed; j++) begin
            if (count_table[i] > top_cnt[j]) begin
               for (int k = ngft_pkg::TOP_COUNT - 1; k > j; k--) begin
                  top_cnt[k] = top_cnt[k-1];
                  top_tok[k] = top_tok[k-1];
               end
               top_cnt[j] = count_table[i];
               top_tok[j] = token_table[i];
               placed     = 1'b1;
            end
         end
      end
      for (int j = 0; j < ngft_pkg::TOP_COUNT; j++) begin
         r.rank     = ngft_pkg::RANK_W'(j);
         r.token    = top_tok[j];
         r.count    = top_cnt[j];
         r.overflow = dropped;
         r.last     = (j == ngft_pkg::TOP_COUNT - 1);
         ranking_q.push_back(r);
      end
   endtask

   task automatic take_request(input logic [1:0] op,
                               input logic [ngft_pkg::CHAR_W-1:0] c);
      case (op)
         ngft_pkg::OP_CHAR: take_char(c);
         ngft_pkg::OP_REPORT: push_ranking();
         ngft_pkg::OP_CLEAR: begin
            table_fill = 0;
            held_valid = 1'b0;
            held_char  = '0;
            dropped    = 1'b0;
         end
         default: ;
      endcase
   endtask

   task automatic check_result();
      ranking_type want;
      if (ranking_q.size() == 0) begin
         report_mismatch("result with no report pending", rsp_token_out, 0);
         return;
      end
      want = ranking_q.pop_front();
      if (rsp_rank !== want.rank)
         report_mismatch("rank", rsp_rank, want.rank);
      if (rsp_token_out !== want.token)
         report_mismatch("token_out", rsp_token_out, want.token);
      if (rsp_count_out !== want.count)
         report_mismatch("count_out", rsp_count_out, want.count);
      if (rsp_overflow !== want.overflow)
         report_mismatch("overflow", rsp_overflow, want.overflow);
      if (rsp_last !== want.last)
         report_mismatch("last", rsp_last, want.last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         excl_char  = ngft_pkg::EXCL_RESET;
         held_char  = '0;
         held_valid = 1'b0;
         table_fill = 0;
         dropped    = 1'b0;
         ranking_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready
             && csr_paddr[ngft_pkg::CSR_ADDR_W-1:2] == ngft_pkg::REG_EXCLUDED) begin
            if (csr_pwrite)
               excl_char = csr_pwdata[ngft_pkg::CHAR_W-1:0];
            else if (csr_prdata[ngft_pkg::CHAR_W-1:0] !== excl_char)
               report_mismatch("excluded_char readback", csr_prdata, excl_char);
         end
         if (req_valid && req_ready)
            take_request(req_operation, req_char_in);
         if (rsp_valid && rsp_ready)
            check_result();
      end
      pending <= ranking_q.size();
   end

endmodule

// ----- dv/ngram_frequency_top_three_test.sv -----
// ----------------------------------------------------------------------------
// ngram_frequency_top_three_test
// Stimulus and verdict for the bigram histogram block. A short directed
// sequence covers whitespace, window fill, excluded windows, empty and
// partial reports, clear and the unused operation. Random phases follow,
// each under a new excluded character: small alphabets build up counts and
// ties, a wide phase fills the table past its depth. Both channels stall
// in random bursts except in the third and the last phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ngram_frequency_top_three_test;

   localparam int         TABLE_DEPTH    = 128;
   localparam logic [1:0] OP_UNUSED      = 2'd3;
   localparam int         SETTLE_CYCLES  = TABLE_DEPTH + 12;
   localparam int         WATCHDOG_LIMIT = 4000;

   typedef enum logic [1:0] {
      MIX_NARROW,
      MIX_WIDE,
      MIX_BLEND
   } char_mix_type;

   logic                            clock         = 1'b0;
   logic                            reset         = 1'b1;
   logic                            req_valid     = 1'b0;
   logic                            req_ready;
   logic [1:0]                      req_operation = ngft_pkg::OP_CHAR;
   logic [ngft_pkg::CHAR_W-1:0]     req_char_in   = '0;
   logic                            rsp_valid;
   logic                            rsp_ready     = 1'b0;
   logic [ngft_pkg::RANK_W-1:0]     rsp_rank;
   logic [ngft_pkg::OUT_TOK_W-1:0]  rsp_token_out;
   logic [ngft_pkg::COUNT_W-1:0]    rsp_count_out;
   logic                            rsp_overflow;
   logic                            rsp_last;
   logic                            csr_psel      = 1'b0;
   logic                            csr_penable   = 1'b0;
   logic                            csr_pwrite    = 1'b0;
   logic [ngft_pkg::CSR_ADDR_W-1:0] csr_paddr     = '0;
   logic [ngft_pkg::CSR_DATA_W-1:0] csr_pwdata    = '0;
   logic [ngft_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   int                              errors;
   int                              pending;
   bit                              idle_on       = 1'b1;
   int                              rsp_hold      = 0;
   int                              stuck_cycles  = 0;
   logic [ngft_pkg::CHAR_W-1:0]     excl_now      = ngft_pkg::EXCL_RESET;

   ngram_frequency_top_three #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_char_in   (req_char_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_rank      (rsp_rank),
      .rsp_token_out (rsp_token_out),
      .rsp_count_out (rsp_count_out),
      .rsp_overflow  (rsp_overflow),
      .rsp_last      (rsp_last),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   ngram_frequency_top_three_check #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_char_in   (req_char_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_rank      (rsp_rank),
      .rsp_token_out (rsp_token_out),
      .rsp_count_out (rsp_count_out),
      .rsp_overflow  (rsp_overflow),
      .rsp_last      (rsp_last),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .errors        (errors),
      .pending       (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // result side: random stall bursts while idling is enabled
   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= (rsp_hold == 1);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_hold  <= $urandom_range(1, 9);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_psel && csr_penable))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles == WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_request(input logic [1:0] op,
                               input logic [ngft_pkg::CHAR_W-1:0] c);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_char_in   <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // all rankings returned, then room for a lookup that yields no result
   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_excluded(input logic [ngft_pkg::CHAR_W-1:0] value);
      logic [ngft_pkg::CSR_DATA_W-1:0] wdata;
      wdata                       = $urandom;
      wdata[ngft_pkg::CHAR_W-1:0] = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {ngft_pkg::REG_EXCLUDED, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      // read back
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      excl_now = value;
   endtask

   function automatic logic [ngft_pkg::CHAR_W-1:0] pick_char(input char_mix_type mix);
      int                          roll;
      int                          pick;
      logic [ngft_pkg::CHAR_W-1:0] c;
      roll = $urandom_range(0, 9);
      pick = $urandom_range(0, 5);
      c    = ngft_pkg::CHAR_W'($urandom_range(0, 255));
      if (mix == MIX_WIDE || (mix == MIX_BLEND && roll >= 5))
         return c;
      if (roll == 0)
         return (pick == 5) ? 8'd32 : 8'd9 + ngft_pkg::CHAR_W'(pick);
      if (roll == 1)
         return excl_now;
      return "a" + pick[1:0];
   endfunction

   task automatic run_phase(input char_mix_type mix,
                            input logic [ngft_pkg::CHAR_W-1:0] excl,
                            input bit idle, input int n_items, input int report_pct,
                            input int clear_pct);
      int         sent;
      int         roll;
      logic [1:0] op;
      sent = 0;
      drain_block();
      write_excluded(excl);
      idle_on = idle;
      if (mix == MIX_WIDE)
         send_request(ngft_pkg::OP_CLEAR, '0);
      while (sent < n_items) begin
         roll = $urandom_range(0, 99);
         if (roll < 3)
            op = OP_UNUSED;
         else if (roll < 3 + report_pct)
            op = ngft_pkg::OP_REPORT;
         else if (roll < 3 + report_pct + clear_pct)
            op = ngft_pkg::OP_CLEAR;
         else
            op = ngft_pkg::OP_CHAR;
         send_request(op, pick_char(mix));
         if (op != OP_UNUSED)
            sent++;
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_request(ngft_pkg::OP_REPORT, 8'hFF);       // empty table
      send_request(ngft_pkg::OP_CHAR, "a");           // window fill
      send_request(ngft_pkg::OP_CHAR, 8'd32);
      send_request(ngft_pkg::OP_CHAR, "b");
      send_request(ngft_pkg::OP_CHAR, 8'd9);
      send_request(ngft_pkg::OP_CHAR, 8'd13);
      send_request(ngft_pkg::OP_CHAR, "a");
      send_request(ngft_pkg::OP_CHAR, "b");
      send_request(ngft_pkg::OP_CHAR, ".");           // excluded on both sides
      send_request(ngft_pkg::OP_CHAR, 8'hFF);
      send_request(ngft_pkg::OP_CHAR, 8'h00);
      send_request(OP_UNUSED, 8'h5A);
      send_request(ngft_pkg::OP_REPORT, 8'h00);
      send_request(ngft_pkg::OP_CLEAR, 8'hA5);
      send_request(ngft_pkg::OP_REPORT, 8'h00);
      send_request(ngft_pkg::OP_CHAR, "x");
      send_request(OP_UNUSED, 8'hFF);
      send_request(ngft_pkg::OP_CHAR, "y");
      send_request(ngft_pkg::OP_REPORT, 8'h00);       // one token only

      run_phase(MIX_NARROW, 8'h00, 1'b1, 70, 12, 3);
      run_phase(MIX_WIDE, 8'hFF, 1'b1, 150, 4, 0);
      run_phase(MIX_NARROW, "a", 1'b0, 60, 12, 3);
      run_phase(MIX_BLEND, ngft_pkg::CHAR_W'($urandom_range(0, 255)), 1'b1, 90, 8, 2);
      run_phase(MIX_NARROW, ngft_pkg::EXCL_RESET, 1'b0, 80, 12, 3);

      drain_block();
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
